// ===== rtl/bsdo_pkg.sv =====
// shared types and constants for the bounded drop-oldest stack
`timescale 1ns / 1ps

package bsdo_pkg;

   localparam int CMD_W   = 2;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH_TOP    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BOTTOM = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP         = 2'd2;

   // request packing: command, value, zero pad to 40 bits
   localparam int REQ_W = 40;
   // response packing: popped_value, dropped, error, entry_count, is_empty, is_full, pad to 48
   localparam int RSP_W = 48;

   typedef struct packed {
      logic capture;   // latch the accepted request
      logic exec;      // apply the command and load the response register
   } bsdo_ctl_type;

endpackage

// ===== rtl/bsdo_ctrl.sv =====
// controller: request/response handshake sequencing
`timescale 1ns / 1ps

module bsdo_ctrl
   import bsdo_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output bsdo_ctl_type ctl
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctl.capture  = 1'b0;
      ctl.exec     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait until the response register can take a new result
            if (rsp_free) begin
               ctl.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/bsdo_dpath.sv =====
// datapath: slot memory, circular bottom pointer, count and response register
`timescale 1ns / 1ps

module bsdo_dpath
   import bsdo_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  bsdo_ctl_type       ctl,
   input  logic [CMD_W-1:0]   command,
   input  logic [VALUE_W-1:0] value,
   output logic [VALUE_W-1:0] popped_value,
   output logic               dropped,
   output logic               error,
   output logic [COUNT_W-1:0] entry_count,
   output logic               is_empty,
   output logic               is_full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [VALUE_W-1:0] mem [DEPTH];

   logic [CMD_W-1:0]   cmd_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [AW-1:0]      bottom_ff;
   logic [AW-1:0]      bottom_in;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               pop_ok_ff;
   logic               pop_ok_in;
   logic               dropped_ff;
   logic               dropped_in;
   logic               error_ff;
   logic               error_in;
   logic [COUNT_W-1:0] entry_count_ff;
   logic               empty_ff;
   logic               full_ff;

   logic               full;
   logic               empty;
   logic [SW-1:0]      push_sum;
   logic [SW-1:0]      pop_sum;
   logic [AW-1:0]      push_idx;
   logic [AW-1:0]      pop_idx;
   logic [AW-1:0]      bottom_inc;
   logic [AW-1:0]      bottom_dec;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   // bottom + count stays below twice the depth, so one subtract wraps it
   assign push_sum = SW'(bottom_ff) + SW'(count_ff);
   assign pop_sum  = push_sum - SW'(1);
   assign push_idx = AW'((push_sum >= DEPTH_S) ? push_sum - DEPTH_S : push_sum);
   assign pop_idx  = AW'((pop_sum >= DEPTH_S) ? pop_sum - DEPTH_S : pop_sum);

   assign bottom_inc = (bottom_ff == LAST_IDX) ? '0 : bottom_ff + AW'(1);
   assign bottom_dec = (bottom_ff == '0) ? LAST_IDX : bottom_ff - AW'(1);

   always_comb begin
      bottom_in  = bottom_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_addr    = push_idx;
      rd_en      = 1'b0;
      pop_ok_in  = 1'b0;
      dropped_in = 1'b0;
      error_in   = 1'b0;
      unique case (cmd_ff)
         CMD_PUSH_TOP: begin
            wr_en = ctl.exec;
            if (full) begin
               // new top lands on the oldest slot
               wr_addr    = bottom_ff;
               bottom_in  = bottom_inc;
               dropped_in = 1'b1;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         CMD_PUSH_BOTTOM: begin
            if (full) begin
               error_in = 1'b1;
            end else begin
               wr_en     = ctl.exec;
               wr_addr   = bottom_dec;
               bottom_in = bottom_dec;
               count_in  = count_ff + CW'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               error_in = 1'b1;
            end else begin
               rd_en     = ctl.exec;
               pop_ok_in = 1'b1;
               count_in  = count_ff - CW'(1);
            end
         end
         default: begin
            error_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff <= '0;
         count_ff  <= '0;
      end else if (ctl.exec) begin
         bottom_ff <= bottom_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= command;
         value_ff <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[pop_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         pop_ok_ff      <= pop_ok_in;
         dropped_ff     <= dropped_in;
         error_ff       <= error_in;
         entry_count_ff <= COUNT_W'(count_in);
         empty_ff       <= (count_in == '0);
         full_ff        <= (count_in == FULL_CNT);
      end
   end

   assign popped_value = pop_ok_ff ? rd_data_ff : '0;
   assign dropped      = dropped_ff;
   assign error        = error_ff;
   assign entry_count  = entry_count_ff;
   assign is_empty     = empty_ff;
   assign is_full      = full_ff;

endmodule

// ===== rtl/bounded_stack_drop_oldest.sv =====
// top level of the bounded LIFO stack that drops its oldest entry on overflow
`timescale 1ns / 1ps
//
// Bounded stack of DEPTH 32-bit words held in a circular slot memory.
// Request channel (req_*): one command per request, push on top, push under
// the bottom, or pop the top. Response channel (rsp_*): exactly one response
// per request, in request order, with the popped word, the dropped and error
// flags, and the count and empty/full flags after the command.
// A push on top of a full stack overwrites the bottom slot and advances the
// bottom pointer. Pop on empty, push-bottom on full and unknown commands are
// rejected with error set and leave the stack unchanged.
// Timing: a request is captured while idle and executed in the execute step,
// when the slot memory is written or read once; the response is valid the
// cycle after that. One request is in flight at a time, so a new request is
// not taken until the last one has executed.
// When the receiver stalls, the response holds and the next accepted request
// waits in its execute step until the response register frees up.
// Reset empties the stack, returns the controller to idle and clears the
// response valid; slot contents are not cleared and need no clearing pass.
//

module bounded_stack_drop_oldest
   import bsdo_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // command[1:0], value[33:2], zero [39:34]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // popped_value[31:0], dropped[32], error[33],
                                         // entry_count[38:34], is_empty[39], is_full[40],
                                         // zero [47:41]
);

   bsdo_ctl_type       ctl;
   logic [VALUE_W-1:0] popped_value;
   logic               dropped;
   logic               error;
   logic [COUNT_W-1:0] entry_count;
   logic               is_empty;
   logic               is_full;

   bsdo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   bsdo_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .command      (req_tdata[CMD_W-1:0]),
      .value        (req_tdata[CMD_W +: VALUE_W]),
      .popped_value (popped_value),
      .dropped      (dropped),
      .error        (error),
      .entry_count  (entry_count),
      .is_empty     (is_empty),
      .is_full      (is_full)
   );

   assign rsp_tdata = {7'b0, is_full, is_empty, entry_count, error, dropped, popped_value};

endmodule

// ===== rtl/bsdo_checker.sv =====
// port-level checks for the bounded stack, bound to the top level
`timescale 1ns / 1ps

module bsdo_assertions
   import bsdo_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // only one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another executes");

   // a dropped entry only happens on a full stack and is never an error
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[40] && !rsp_tdata[33])
      else $error("dropped without a full stack");

   // a rejected request returns no data and drops nothing
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[31:0] == '0 && !rsp_tdata[32])
      else $error("rejected request returned data");

   // empty stack reports a zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39] |-> rsp_tdata[38:34] == '0 && !rsp_tdata[40])
      else $error("empty flag with nonzero count");

endmodule

bind bounded_stack_drop_oldest bsdo_assertions u_bsdo_assertions (.*);
